/* hw/rtl/wsh_pkg.sv */
// ----------------------------------------------------------------------------
// wsh_pkg
// Shared constants and types for the window stack hit test block.
// ----------------------------------------------------------------------------
package wsh_pkg;

    localparam int MAX_WINDOWS_DEF = 16;
    localparam int CASCADE_STEPS   = 6;
    localparam int CASCADE_SHIFT   = 5;   // 32 pixels per cascade step

    localparam logic [12:0] OUT_W_RST = 13'd1024;
    localparam logic [12:0] OUT_H_RST = 13'd768;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_FREE  = 3'd1;
    localparam logic [2:0] OP_RAISE = 3'd2;
    localparam logic [2:0] OP_RECT  = 3'd3;
    localparam logic [2:0] OP_PLACE = 3'd4;
    localparam logic [2:0] OP_HIT   = 3'd5;
    localparam logic [2:0] OP_FOCUS = 3'd6;

    localparam logic CFG_OUT_W = 1'b0;
    localparam logic CFG_OUT_H = 1'b1;

    typedef struct packed {
        logic [11:0]        h;
        logic [11:0]        w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } rect_t;

endpackage

/* hw/rtl/wsh_rect_ram.sv */
// ----------------------------------------------------------------------------
// wsh_rect_ram
// Window rectangle store: one write and one registered read per cycle,
// entries read as zero until first written after reset.
// ----------------------------------------------------------------------------
module wsh_rect_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  wsh_pkg::rect_t wdata,
    input  logic [AW-1:0] raddr,
    output wsh_pkg::rect_t rdata
);
    import wsh_pkg::*;

    rect_t            mem [DEPTH];
    rect_t            q_reg;
    logic             qv_reg;
    logic [DEPTH-1:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        q_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            qv_reg  <= 1'b0;
        end else begin
            qv_reg <= vld_reg[raddr];
            if (we) begin
                vld_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rdata = qv_reg ? q_reg : '0;

endmodule

/* hw/rtl/window_stack_hit_test.sv */
// ----------------------------------------------------------------------------
// window_stack_hit_test
// Window slot table with stacking order, placement and point hit test.
// ----------------------------------------------------------------------------
// One request enters on the s_ channel (op in s_tuser, operands in s_tdata)
// and exactly one result leaves on the m_ channel. Requests are handled one
// at a time; s_tready is high only while the sequencer is idle.
// Sequence from acceptance to m_tvalid: set rect and the other single-step
// requests go straight to the done state; place reads, then writes the
// rectangle; alloc and raise compact the stack (one stack memory read per
// cycle), free first clears the rectangle size; hit test and focus walk the
// stack (stack read, rectangle read, check per entry, top first).
// The output register holds a result until taken; the next request is
// accepted meanwhile, and only its completion waits for m_tready.
// Reset (synchronous, aresetn low) empties the stack, clears all slots and the
// cascade phase and loads output size 1024 x 768. The user writes output size
// via cfg_we/cfg_addr/cfg_wdata only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module window_stack_hit_test #(
    parameter int MAX_WINDOWS = wsh_pkg::MAX_WINDOWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // window_index, pos_x, pos_y, width, height,
                                  // mapped_flag, popup_flag
    input  logic [2:0]  s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // found, result_window, local_x, local_y
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [12:0] cfg_wdata
);
    import wsh_pkg::*;

    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CW = $clog2(MAX_WINDOWS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RM   = 4'd1;
    localparam logic [3:0] S_FR_R = 4'd2;
    localparam logic [3:0] S_FR_W = 4'd3;
    localparam logic [3:0] S_PL_R = 4'd4;
    localparam logic [3:0] S_PL_W = 4'd5;
    localparam logic [3:0] S_WK_S = 4'd6;
    localparam logic [3:0] S_WK_R = 4'd7;
    localparam logic [3:0] S_WK_C = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    // input fields
    logic [3:0]         in_idx;
    logic signed [15:0] in_x, in_y;
    logic [11:0]        in_w, in_h;
    logic               in_map, in_pop;
    assign in_idx = s_tdata[3:0];
    assign in_x   = s_tdata[19:4];
    assign in_y   = s_tdata[35:20];
    assign in_w   = s_tdata[47:36];
    assign in_h   = s_tdata[59:48];
    assign in_map = s_tdata[60];
    assign in_pop = s_tdata[61];

    logic [IW-1:0] in_slot;
    logic          in_ok;
    assign in_slot = IW'(in_idx);
    assign in_ok   = 32'(in_idx) < MAX_WINDOWS;

    logic [3:0]             state_reg;
    logic [2:0]             op_reg;
    logic [IW-1:0]          tgt_reg;
    logic                   push_reg;
    logic signed [15:0]     px_reg, py_reg;
    logic [CW-1:0]          count_reg, kept_reg, rd_ptr_reg, walk_reg;
    logic                   pend_reg;
    logic [2:0]             phase_reg;
    logic [12:0]            ow_reg, oh_reg;
    logic [MAX_WINDOWS-1:0] used_reg, mapped_reg, popup_reg;
    logic                   res_found_reg;
    logic [3:0]             res_win_reg;
    logic signed [15:0]     res_lx_reg, res_ly_reg;
    logic                   out_valid_reg;
    logic [39:0]            out_data_reg;

    // stack memory
    logic [IW-1:0] stack_mem [MAX_WINDOWS];
    logic [IW-1:0] stack_q;
    logic          st_we;
    logic [IW-1:0] st_waddr, st_wdata, st_raddr;

    always_ff @(posedge aclk) begin
        if (st_we) begin
            stack_mem[st_waddr] <= st_wdata;
        end
        stack_q <= stack_mem[st_raddr];
    end

    // rectangle memory
    logic          rc_we;
    logic [IW-1:0] rc_waddr, rc_raddr;
    rect_t         rc_wdata, rc_q;

    wsh_rect_ram #(.DEPTH(MAX_WINDOWS), .AW(IW)) u_rect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (rc_we),
        .waddr   (rc_waddr),
        .wdata   (rc_wdata),
        .raddr   (rc_raddr),
        .rdata   (rc_q)
    );

    // first free slot
    logic          free_any;
    logic [IW-1:0] free_slot;
    always_comb begin
        free_any  = 1'b0;
        free_slot = '0;
        for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_any  = 1'b1;
                free_slot = IW'(i);
            end
        end
    end

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    logic rm_fin;
    assign rm_fin = !pend_reg && (rd_ptr_reg >= count_reg);

    // placement
    logic signed [16:0] pl_dx, pl_dy, pl_x, pl_y, pl_x1, pl_y1, pl_x2, pl_y2;
    logic signed [16:0] pl_ow, pl_oh, pl_w, pl_h, pl_step;
    always_comb begin
        pl_ow   = $signed({4'b0, ow_reg});
        pl_oh   = $signed({4'b0, oh_reg});
        pl_w    = $signed({5'b0, rc_q.w});
        pl_h    = $signed({5'b0, rc_q.h});
        pl_step = $signed({9'b0, phase_reg, 5'b0});
        pl_dx   = pl_ow - pl_w;
        pl_dy   = pl_oh - pl_h;
        pl_x1   = ((pl_dx + $signed({16'b0, pl_dx[16]})) >>> 1) + pl_step;
        pl_y1   = ((pl_dy + $signed({16'b0, pl_dy[16]})) >>> 1) + pl_step;
        pl_x2   = (pl_x1 + pl_w > pl_ow) ? pl_dx : pl_x1;
        pl_y2   = (pl_y1 + pl_h > pl_oh) ? pl_dy : pl_y1;
        pl_x    = pl_x2[16] ? '0 : pl_x2;
        pl_y    = pl_y2[16] ? '0 : pl_y2;
    end

    // hit check
    logic signed [17:0] hk_px, hk_py, hk_wx, hk_wy;
    logic               hk_ok, hk_live;
    always_comb begin
        hk_px   = 18'(px_reg);
        hk_py   = 18'(py_reg);
        hk_wx   = 18'(rc_q.x);
        hk_wy   = 18'(rc_q.y);
        hk_live = used_reg[tgt_reg] && mapped_reg[tgt_reg];
        hk_ok   = hk_live && (rc_q.w != '0) && (rc_q.h != '0)
                  && (hk_px >= hk_wx) && (hk_py >= hk_wy)
                  && (hk_px < hk_wx + $signed({6'b0, rc_q.w}))
                  && (hk_py < hk_wy + $signed({6'b0, rc_q.h}));
    end

    always_comb begin
        st_we    = 1'b0;
        st_waddr = kept_reg[IW-1:0];
        st_wdata = stack_q;
        st_raddr = rd_ptr_reg[IW-1:0];
        rc_we    = 1'b0;
        rc_waddr = tgt_reg;
        rc_wdata = rc_q;
        rc_raddr = in_slot;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && s_tuser == OP_RECT && in_ok) begin
                    rc_we    = 1'b1;
                    rc_waddr = in_slot;
                    rc_wdata = '{h: in_h, w: in_w, y: in_y, x: in_x};
                end else if (accept && s_tuser == OP_ALLOC && free_any) begin
                    rc_we    = 1'b1;
                    rc_waddr = free_slot;
                    rc_wdata = '0;
                end
            end
            S_RM: begin
                if (pend_reg && stack_q != tgt_reg) begin
                    st_we = 1'b1;
                end else if (rm_fin && push_reg && kept_reg < CW'(MAX_WINDOWS)) begin
                    st_we    = 1'b1;
                    st_wdata = tgt_reg;
                end
            end
            S_FR_R: rc_raddr = tgt_reg;
            S_FR_W: begin
                rc_we      = 1'b1;
                rc_wdata.w = '0;
                rc_wdata.h = '0;
            end
            S_PL_R: rc_raddr = tgt_reg;
            S_PL_W: begin
                rc_we      = 1'b1;
                rc_wdata.x = 16'(pl_x);
                rc_wdata.y = 16'(pl_y);
            end
            S_WK_S: st_raddr = walk_reg[IW-1:0] - 1'b1;
            S_WK_R: rc_raddr = stack_q;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            phase_reg     <= '0;
            ow_reg        <= OUT_W_RST;
            oh_reg        <= OUT_H_RST;
            used_reg      <= '0;
            mapped_reg    <= '0;
            popup_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_OUT_W: ow_reg <= cfg_wdata;
                    CFG_OUT_H: oh_reg <= cfg_wdata;
                endcase
            end
            if (m_tvalid && m_tready && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        op_reg        <= s_tuser;
                        tgt_reg       <= in_slot;
                        px_reg        <= in_x;
                        py_reg        <= in_y;
                        res_found_reg <= 1'b0;
                        res_win_reg   <= '0;
                        res_lx_reg    <= '0;
                        res_ly_reg    <= '0;
                        kept_reg      <= '0;
                        rd_ptr_reg    <= '0;
                        pend_reg      <= 1'b0;
                        walk_reg      <= count_reg;
                        state_reg     <= S_DONE;
                        unique case (s_tuser)
                            OP_ALLOC: if (free_any) begin
                                used_reg[free_slot]   <= 1'b1;
                                mapped_reg[free_slot] <= 1'b0;
                                popup_reg[free_slot]  <= 1'b0;
                                tgt_reg               <= free_slot;
                                push_reg              <= 1'b1;
                                res_found_reg         <= 1'b1;
                                res_win_reg           <= 4'(free_slot);
                                state_reg             <= S_RM;
                            end
                            OP_FREE: if (in_ok && used_reg[in_slot]) begin
                                used_reg[in_slot]   <= 1'b0;
                                mapped_reg[in_slot] <= 1'b0;
                                push_reg            <= 1'b0;
                                state_reg           <= S_FR_R;
                            end
                            OP_RAISE: if (in_ok) begin
                                push_reg  <= 1'b1;
                                state_reg <= S_RM;
                            end
                            OP_RECT: if (in_ok) begin
                                mapped_reg[in_slot] <= in_map;
                                popup_reg[in_slot]  <= in_pop;
                            end
                            OP_PLACE: if (in_ok && !popup_reg[in_slot]) begin
                                state_reg <= S_PL_R;
                            end
                            OP_HIT, OP_FOCUS: if (count_reg != '0) begin
                                state_reg <= S_WK_S;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RM: begin
                    if (pend_reg && stack_q != tgt_reg) begin
                        kept_reg <= kept_reg + 1'b1;
                    end
                    if (rm_fin) begin
                        if (push_reg && kept_reg < CW'(MAX_WINDOWS)) begin
                            count_reg <= kept_reg + 1'b1;
                        end else begin
                            count_reg <= kept_reg;
                        end
                        state_reg <= S_DONE;
                    end else if (rd_ptr_reg < count_reg) begin
                        rd_ptr_reg <= rd_ptr_reg + 1'b1;
                        pend_reg   <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                    end
                end
                S_FR_R: state_reg <= S_FR_W;
                S_FR_W: state_reg <= S_RM;
                S_PL_R: state_reg <= S_PL_W;
                S_PL_W: begin
                    phase_reg <= (32'(phase_reg) == CASCADE_STEPS - 1) ? '0
                                 : phase_reg + 1'b1;
                    state_reg <= S_DONE;
                end
                S_WK_S: state_reg <= S_WK_R;
                S_WK_R: begin
                    tgt_reg   <= stack_q;
                    state_reg <= S_WK_C;
                end
                S_WK_C: begin
                    if ((op_reg == OP_HIT) ? hk_ok : hk_live) begin
                        res_found_reg <= 1'b1;
                        res_win_reg   <= 4'(tgt_reg);
                        if (op_reg == OP_HIT) begin
                            res_lx_reg <= 16'(hk_px - hk_wx);
                            res_ly_reg <= 16'(hk_py - hk_wy);
                        end
                        state_reg <= S_DONE;
                    end else if (walk_reg == CW'(1)) begin
                        state_reg <= S_DONE;
                    end else begin
                        walk_reg  <= walk_reg - 1'b1;
                        state_reg <= S_WK_S;
                    end
                end
                S_DONE: begin
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'b0, res_ly_reg, res_lx_reg,
                                          res_win_reg, res_found_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_WINDOWS))
        else $error("stack count beyond slot count");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(phase_reg) < CASCADE_STEPS)
        else $error("cascade phase out of range");

    a_kept_le_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RM) |-> (kept_reg <= rd_ptr_reg))
        else $error("stack compaction overtook its read pointer");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

endmodule

/* tb/sv/tb_window_stack_hit_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_window_stack_hit_test
// Self-checking bench: directed table, then random window-manager traffic,
// each result compared with an in-bench model of the slot table and stack.
// ----------------------------------------------------------------------------
module tb_window_stack_hit_test;
    import wsh_pkg::*;

    localparam int NWIN = 16;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic               found;
        logic [3:0]         win;
        logic signed [15:0] lx;
        logic signed [15:0] ly;
    } res_t;

    typedef struct {
        logic [2:0]         op;
        logic [3:0]         idx;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [11:0]        w;
        logic [11:0]        h;
        logic               mf;
        logic               pf;
        logic               chk;
        res_t               exp_res;
    } req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [12:0] cfg_wdata = '0;

    window_stack_hit_test i_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // window table copy
    logic               m_used[NWIN], m_mapped[NWIN], m_popup[NWIN];
    logic signed [15:0] m_x[NWIN], m_y[NWIN];
    logic [11:0]        m_w[NWIN], m_h[NWIN];
    int                 m_stack[$];
    int                 m_phase;
    int                 out_w, out_h;

    res_t   pending_res[$];
    logic   pending_chk[$];
    res_t   pending_typed[$];
    int     errors = 0, n_in = 0, n_out = 0, n_hits = 0;
    bit     stim_done = 0;
    int     idle_cycles = 0;
    int     rx_wait = 0, rx_seen = 0;

    function automatic void stack_pull(input int s);
        for (int i = m_stack.size() - 1; i >= 0; i--)
            if (m_stack[i] == s) m_stack.delete(i);
    endfunction

    function automatic res_t window_op(input req_t r);
        res_t o;
        int x, y, st;
        int px, py;
        o = '0;
        px = r.px;
        py = r.py;
        case (r.op)
            OP_ALLOC: begin
                for (int i = 0; i < NWIN; i++) begin
                    if (!m_used[i]) begin
                        m_used[i] = 1; m_mapped[i] = 0; m_popup[i] = 0;
                        m_x[i] = 0; m_y[i] = 0; m_w[i] = 0; m_h[i] = 0;
                        stack_pull(i);
                        m_stack.push_back(i);
                        o.found = 1; o.win = 4'(i);
                        break;
                    end
                end
            end
            OP_FREE: if (m_used[r.idx]) begin
                stack_pull(r.idx);
                m_used[r.idx] = 0; m_mapped[r.idx] = 0;
                m_w[r.idx] = 0; m_h[r.idx] = 0;
            end
            OP_RAISE: begin
                stack_pull(r.idx);
                m_stack.push_back(r.idx);
            end
            OP_RECT: begin
                m_x[r.idx] = r.px; m_y[r.idx] = r.py;
                m_w[r.idx] = r.w; m_h[r.idx] = r.h;
                m_mapped[r.idx] = r.mf; m_popup[r.idx] = r.pf;
            end
            OP_PLACE: if (!m_popup[r.idx]) begin
                st = m_phase * 32;
                m_phase = (m_phase + 1) % CASCADE_STEPS;
                x = (out_w - int'(m_w[r.idx])) / 2 + st;
                y = (out_h - int'(m_h[r.idx])) / 2 + st;
                if (x + int'(m_w[r.idx]) > out_w) x = out_w - int'(m_w[r.idx]);
                if (y + int'(m_h[r.idx]) > out_h) y = out_h - int'(m_h[r.idx]);
                if (x < 0) x = 0;
                if (y < 0) y = 0;
                m_x[r.idx] = x[15:0];
                m_y[r.idx] = y[15:0];
            end
            OP_HIT: for (int i = m_stack.size() - 1; i >= 0; i--) begin
                int s, wx, wy;
                s = m_stack[i];
                wx = m_x[s];
                wy = m_y[s];
                if (!m_used[s] || !m_mapped[s] || m_w[s] == 0 || m_h[s] == 0) continue;
                if (px < wx || py < wy) continue;
                if (px >= wx + int'(m_w[s]) || py >= wy + int'(m_h[s])) continue;
                o.found = 1; o.win = 4'(s);
                o.lx = 16'(px - wx); o.ly = 16'(py - wy);
                break;
            end
            OP_FOCUS: for (int i = m_stack.size() - 1; i >= 0; i--) begin
                if (m_used[m_stack[i]] && m_mapped[m_stack[i]]) begin
                    o.found = 1; o.win = 4'(m_stack[i]);
                    break;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic send(input req_t r);
        int gap;
        res_t e;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  <= r.op;
        s_tdata  <= {2'd0, r.pf, r.mf, r.h, r.w, r.py, r.px, r.idx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        e = window_op(r);
        pending_res.push_back(e);
        pending_chk.push_back(r.chk);
        pending_typed.push_back(r.exp_res);
        n_in++;
        @(negedge aclk);
    endtask

    task automatic set_output(input int w, input int h);
        s_tvalid <= 1'b0;
        wait (pending_res.size() == 0);
        repeat (60) @(negedge aclk);
        cfg_we <= 1'b1; cfg_addr <= CFG_OUT_W; cfg_wdata <= 13'(w);
        @(negedge aclk);
        cfg_addr <= CFG_OUT_H; cfg_wdata <= 13'(h);
        @(negedge aclk);
        cfg_we <= 1'b0;
        out_w = w;
        out_h = h;
    endtask

    function automatic req_t mk(input logic [2:0] op, input int idx, input int px,
                                input int py, input int w, input int h,
                                input bit mf, input bit pf);
        req_t r;
        r.op = op; r.idx = 4'(idx); r.px = 16'(px); r.py = 16'(py);
        r.w = 12'(w); r.h = 12'(h);
        r.mf = mf; r.pf = pf; r.chk = 0; r.exp_res = '0;
        return r;
    endfunction

    function automatic req_t mkx(input req_t r, input res_t e);
        r.chk = 1;
        r.exp_res = e;
        return r;
    endfunction

    function automatic req_t rand_req(input int weighted_hits);
        req_t r;
        int k;
        k = $urandom_range(0, 99);
        r = mk(OP_ALLOC, $urandom_range(0, 15), $urandom, $urandom, $urandom_range(0, 4095),
               $urandom_range(0, 4095), $urandom_range(0, 1), $urandom_range(0, 1));
        if (k < 10)       r.op = OP_ALLOC;
        else if (k < 18)  r.op = OP_FREE;
        else if (k < 28)  r.op = OP_RAISE;
        else if (k < 48) begin
            r.op = OP_RECT;
            if ($urandom_range(0, 3) != 0) begin
                r.px = 16'($urandom_range(0, 1200) - 200);
                r.py = 16'($urandom_range(0, 1000) - 200);
                r.w = 12'($urandom_range(0, 600));
                r.h = 12'($urandom_range(0, 600));
                r.pf = ($urandom_range(0, 4) == 0);
                r.mf = ($urandom_range(0, 4) != 0);
            end
        end
        else if (k < 58)  r.op = OP_PLACE;
        else if (k < 85) begin
            r.op = OP_HIT;
            if ($urandom_range(0, 4) != 0) begin
                r.px = 16'($urandom_range(0, 1400) - 200);
                r.py = 16'($urandom_range(0, 1200) - 200);
            end
        end
        else if (k < 97)  r.op = OP_FOCUS;
        else              r.op = 3'd7;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            res_t got, e;
            got.found = m_tdata[0];
            got.win   = m_tdata[4:1];
            got.lx    = m_tdata[20:5];
            got.ly    = m_tdata[36:21];
            n_out++;
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                e = pending_res.pop_front();
                if (pending_chk.pop_front() && pending_typed[0] != e) begin
                    $display("%0t: table row expects %h, predictor %h", $time,
                             pending_typed[0], e);
                    errors++;
                end
                void'(pending_typed.pop_front());
                if (got.found) n_hits++;
                if (got.found !== e.found || got.win !== e.win || got.lx !== e.lx
                    || got.ly !== e.ly || m_tdata[39:37] !== 3'b0) begin
                    $display("%0t: mismatch expected f=%0d w=%0d x=%0d y=%0d actual %h",
                             $time, e.found, e.win, e.lx, e.ly, m_tdata);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = $urandom_range(0, 8);
        end else begin
            if (n_out != rx_seen) begin
                rx_seen = n_out;
                rx_wait = $urandom_range(0, 8);
            end
            if (rx_wait == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_wait--;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        req_t dir[$];
        res_t z;
        int cfgs[4][2] = '{'{1024, 768}, '{1, 1}, '{4096, 4096}, '{640, 480}};
        z = '0;
        for (int i = 0; i < NWIN; i++) begin
            m_used[i] = 0; m_mapped[i] = 0; m_popup[i] = 0;
            m_x[i] = 0; m_y[i] = 0; m_w[i] = 0; m_h[i] = 0;
        end
        m_phase = 0;
        out_w = OUT_W_RST;
        out_h = OUT_H_RST;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        dir.push_back(mkx(mk(OP_FOCUS, 0, 0, 0, 0, 0, 0, 0), z));
        dir.push_back(mkx(mk(OP_HIT, 0, 0, 0, 0, 0, 0, 0), z));
        dir.push_back(mkx(mk(OP_FREE, 3, 0, 0, 0, 0, 0, 0), z));
        dir.push_back(mkx(mk(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0), '{1, 0, 0, 0}));
        dir.push_back(mkx(mk(OP_ALLOC, 0, 0, 0, 0, 0, 0, 0), '{1, 1, 0, 0}));
        dir.push_back(mkx(mk(OP_RECT, 0, -32768, -32768, 4095, 4095, 1, 0), z));
        dir.push_back(mkx(mk(OP_HIT, 0, -32768, -32768, 0, 0, 0, 0), '{1, 0, 0, 0}));
        dir.push_back(mk(OP_HIT, 0, -28674, -28674, 0, 0, 0, 0));
        dir.push_back(mk(OP_RECT, 1, 32767, 32767, 1, 1, 1, 1));
        dir.push_back(mk(OP_HIT, 0, 32767, 32767, 0, 0, 0, 0));
        dir.push_back(mk(OP_PLACE, 1, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_PLACE, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_RECT, 1, 5, 5, 3000, 10, 1, 0));
        for (int i = 0; i < 6; i++) dir.push_back(mk(OP_PLACE, 1, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_RAISE, 15, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_RECT, 15, 0, 0, 0, 0, 1, 0));
        dir.push_back(mk(OP_FOCUS, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mkx(mk(3'd7, 15, -1, -1, 4095, 4095, 1, 1), z));
        dir.push_back(mk(OP_FREE, 0, 0, 0, 0, 0, 0, 0));
        dir.push_back(mk(OP_FOCUS, 0, 0, 0, 0, 0, 0, 0));
        foreach (dir[i]) send(dir[i]);

        for (int ph = 0; ph < 4; ph++) begin
            set_output(cfgs[ph][0], cfgs[ph][1]);
            for (int n = 0; n < 120; n++) send(rand_req(1));
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
        wait (pending_res.size() == 0);
        repeat (80) @(posedge aclk);
        $display("Covered %0d requests, %0d results, %0d with a slot found,", n_in, n_out,
                 n_hits);
        $display("over four output sizes including 1x1 and 4096x4096.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
